// ===== rtl/core/hspv_pkg.sv =====
package hspv_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 8;

    localparam int NUM_HALL_POS = 6;
    localparam int POS_W        = 3;
    localparam int STATE_W      = 3;
    localparam int SECTOR_W     = 4;
    localparam int COUNT_W      = 32;
    localparam int TIME_W       = 32;
    localparam int INTERVAL_W   = 20;
    localparam int SCALE_W      = 24;
    localparam int VEL_W        = 32;
    localparam int PROD_W       = COUNT_W + SCALE_W + 1;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);
    localparam logic [SCALE_W-1:0]    SCALE_RESET    = SCALE_W'(32000);

    localparam logic [STATE_W-1:0]  STATE_NONE  = 3'd0;
    localparam logic [STATE_W-1:0]  STATE_ALL   = 3'd7;
    localparam logic [SECTOR_W-1:0] SECTOR_NONE = 4'b1111;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_ZERO   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SKIP    = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_POS1     = 3'd0,
        REG_POS2     = 3'd1,
        REG_POS3     = 3'd2,
        REG_POS4     = 3'd3,
        REG_POS5     = 3'd4,
        REG_POS6     = 3'd5,
        REG_INTERVAL = 3'd6,
        REG_SCALE    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [NUM_HALL_POS-1:0][POS_W-1:0] hall_pos;
        logic [INTERVAL_W-1:0]              interval;
        logic [SCALE_W-1:0]                 scale;
    } cfg_t;

    // decoded item, handed from the decode stage to the velocity stage
    typedef struct packed {
        logic                zero;
        logic                sampled;
        logic [COUNT_W-1:0]  count;
        logic [COUNT_W-1:0]  diff;
        logic [SECTOR_W-1:0] sector;
        logic [STATE_W-1:0]  hall_state;
        status_t             status;
    } stage_t;

    // calibrated sector of a valid Hall state 1..6
    function automatic logic [POS_W-1:0] sector_lookup(
        input logic [NUM_HALL_POS-1:0][POS_W-1:0] pos,
        input logic [STATE_W-1:0]                 s
    );
        logic [POS_W-1:0] r;
        case (s)
            3'd1:    r = pos[0];
            3'd2:    r = pos[1];
            3'd3:    r = pos[2];
            3'd4:    r = pos[3];
            3'd5:    r = pos[4];
            3'd6:    r = pos[5];
            default: r = '0;
        endcase
        return r;
    endfunction

    // (p + 1) mod 6 for any 3-bit p
    function automatic logic [POS_W-1:0] sector_fwd(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        case (p)
            3'd5:    r = 3'd0;
            3'd6:    r = 3'd1;
            3'd7:    r = 3'd2;
            default: r = p + 3'd1;
        endcase
        return r;
    endfunction

    // (p - 1) mod 6, with 0 going back to 5
    function automatic logic [POS_W-1:0] sector_back(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        case (p)
            3'd0:    r = 3'd5;
            3'd7:    r = 3'd0;
            default: r = p - 3'd1;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/hspv_decode.sv =====
module hspv_decode #(
    parameter int WINDOW_DEPTH = hspv_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           op,
    input  logic                           hall_a,
    input  logic                           hall_b,
    input  logic                           hall_z,
    input  logic [hspv_pkg::TIME_W-1:0]    now_us,
    input  hspv_pkg::cfg_t                 cfg,
    output hspv_pkg::stage_t               stage
);
    import hspv_pkg::*;

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

    logic [COUNT_W-1:0] count_reg;
    logic [STATE_W-1:0] prev_state_reg;
    logic [COUNT_W-1:0] window_reg [WINDOW_DEPTH];
    logic [IDX_W-1:0]   window_index_reg;
    logic [TIME_W-1:0]  last_sample_reg;
    stage_t             stage_reg;

    logic [STATE_W-1:0] raw_state;
    logic [STATE_W-1:0] cur_state;
    logic               cur_valid;
    logic               prev_valid;
    logic [POS_W-1:0]   old_pos;
    logic [POS_W-1:0]   new_pos;
    logic [COUNT_W-1:0] count_next;
    status_t            status_next;
    logic [TIME_W-1:0]  elapsed;
    logic               sample_hit;
    logic [COUNT_W-1:0] oldest;
    logic [IDX_W-1:0]   window_index_next;
    logic [STATE_W-1:0] shown_state;
    stage_t             stage_next;

    always_comb
    begin
        raw_state  = {hall_a, hall_b, hall_z};
        cur_valid  = (raw_state != STATE_NONE) && (raw_state != STATE_ALL);
        cur_state  = cur_valid ? raw_state : STATE_NONE;
        prev_valid = (prev_state_reg != STATE_NONE);
        old_pos    = sector_lookup(cfg.hall_pos, prev_state_reg);
        new_pos    = sector_lookup(cfg.hall_pos, cur_state);

        count_next  = count_reg;
        status_next = STATUS_OK;
        if (!cur_valid)
        begin
            status_next = STATUS_INVALID;
        end
        else if (prev_valid)
        begin
            if (new_pos == sector_fwd(old_pos))
                count_next = count_reg + COUNT_W'(1);
            else if (new_pos == sector_back(old_pos))
                count_next = count_reg - COUNT_W'(1);
            else if (new_pos != old_pos)
                status_next = STATUS_SKIP;
        end

        elapsed    = now_us - last_sample_reg;
        sample_hit = (elapsed >= TIME_W'(cfg.interval));
        oldest     = window_reg[window_index_reg];
        window_index_next = (window_index_reg == LAST_IDX) ? '0
                                                           : window_index_reg + IDX_W'(1);

        // zero op shows the kept previous state
        shown_state = (op_t'(op) == OP_ZERO) ? prev_state_reg : cur_state;

        stage_next.zero       = (op_t'(op) == OP_ZERO);
        stage_next.sampled    = sample_hit;
        stage_next.count      = (op_t'(op) == OP_ZERO) ? '0 : count_next;
        stage_next.diff       = count_next - oldest;
        stage_next.hall_state = shown_state;
        stage_next.sector     = (shown_state != STATE_NONE)
                                ? {1'b0, sector_lookup(cfg.hall_pos, shown_state)}
                                : SECTOR_NONE;
        stage_next.status     = (op_t'(op) == OP_ZERO) ? STATUS_OK : status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            prev_state_reg   <= STATE_NONE;
            window_index_reg <= '0;
            last_sample_reg  <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                window_reg[i] <= '0;
        end
        else if (accept)
        begin
            if (op_t'(op) == OP_ZERO)
            begin
                count_reg <= '0;
                for (int i = 0; i < WINDOW_DEPTH; i++)
                    window_reg[i] <= '0;
            end
            else
            begin
                count_reg      <= count_next;
                prev_state_reg <= cur_state;
                if (sample_hit)
                begin
                    last_sample_reg              <= last_sample_reg + TIME_W'(cfg.interval);
                    window_reg[window_index_reg] <= count_next;
                    window_index_reg             <= window_index_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= stage_next;
    end

    assign stage = stage_reg;

endmodule

// ===== rtl/core/hspv_velocity.sv =====
module hspv_velocity (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  hspv_pkg::stage_t                    stage,
    input  logic [hspv_pkg::SCALE_W-1:0]        scale,
    output logic signed [hspv_pkg::COUNT_W-1:0] position,
    output logic signed [hspv_pkg::SECTOR_W-1:0] sector,
    output logic [hspv_pkg::STATE_W-1:0]        hall_state,
    output logic signed [hspv_pkg::VEL_W-1:0]   velocity_q8,
    output logic [1:0]                          status
);
    import hspv_pkg::*;

    localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    logic [VEL_W-1:0]    velocity_reg;
    logic [COUNT_W-1:0]  position_reg;
    logic [SECTOR_W-1:0] sector_reg;
    logic [STATE_W-1:0]  hall_state_reg;
    status_t             status_reg;

    logic signed [PROD_W-1:0] product;
    logic                     over_hi;
    logic                     over_lo;
    logic [VEL_W-1:0]         sat;
    logic [VEL_W-1:0]         velocity_next;

    always_comb
    begin
        product = $signed(stage.diff) * $signed({1'b0, scale});
        // upper bits not all equal to the sign means out of 32-bit range
        over_hi = !product[PROD_W-1] && (|product[PROD_W-2:VEL_W-1]);
        over_lo = product[PROD_W-1] && !(&product[PROD_W-2:VEL_W-1]);
        if (over_hi)
            sat = VEL_MAX;
        else if (over_lo)
            sat = VEL_MIN;
        else
            sat = product[VEL_W-1:0];

        if (stage.zero)
            velocity_next = '0;
        else if (stage.sampled)
            velocity_next = sat;
        else
            velocity_next = velocity_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            velocity_reg <= '0;
        else if (load)
            velocity_reg <= velocity_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            position_reg   <= stage.count;
            sector_reg     <= stage.sector;
            hall_state_reg <= stage.hall_state;
            status_reg     <= stage.status;
        end
    end

    assign position    = $signed(position_reg);
    assign sector      = $signed(sector_reg);
    assign hall_state  = hall_state_reg;
    assign velocity_q8 = $signed(velocity_reg);
    assign status      = status_reg;

endmodule

// ===== rtl/core/hall_sensor_position_velocity.sv =====
// Hall sensor position and velocity decoder.
// Input channel (in_valid/in_stall) carries op, hall_a/b/z and now_us; a sample
// op updates the signed sector count from the calibrated Hall state and, once
// per sample interval, writes the count into a ring window and recomputes the
// velocity from the oldest window entry. A zero op clears count, velocity and
// window. Output channel (out_valid/out_stall) returns one result per item:
// position, sector, hall_state, velocity_q8, status.
// Pipeline: an accepted item passes the decode register, then the
// multiply/saturate result register, before its result is valid.
// Throughput: one item per cycle unless the output stalls; the count/window
// update is done in decode, the 32x24 velocity multiply in the output stage.
// Stall: while the output register is stalled, one more item is held in the
// decode register, after which in_stall rises. Nothing is dropped.
// Reset: clears count, state, window, velocity and the pipeline valids;
// calibration resets to 0, sample interval to 1000 us, scale to 32000. The user
// writes configuration (APB, 4 bytes/register) while idle; block won't check.
module hall_sensor_position_velocity #(
    parameter int WINDOW_DEPTH = hspv_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic                                 hall_a,
    input  logic                                 hall_b,
    input  logic                                 hall_z,
    input  logic [hspv_pkg::TIME_W-1:0]          now_us,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [hspv_pkg::COUNT_W-1:0]  position,
    output logic signed [hspv_pkg::SECTOR_W-1:0] sector,
    output logic [hspv_pkg::STATE_W-1:0]         hall_state,
    output logic signed [hspv_pkg::VEL_W-1:0]    velocity_q8,
    output logic [1:0]                           status,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hspv_pkg::ADDR_W-1:0]          paddr,
    input  logic [hspv_pkg::DATA_W-1:0]          pwdata,
    output logic [hspv_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import hspv_pkg::*;

    logic [NUM_HALL_POS-1:0][POS_W-1:0] hall_pos_reg;
    logic [INTERVAL_W-1:0]              interval_reg;
    logic [SCALE_W-1:0]                 scale_reg;
    logic                               a_valid_reg;
    logic                               out_valid_reg;

    cfg_t     cfg;
    reg_idx_t reg_idx;
    logic     cfg_write;
    logic     b_block;
    logic     in_accept;
    logic     a_move;
    stage_t   stage;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hall_pos_reg <= '0;
            interval_reg <= INTERVAL_RESET;
            scale_reg    <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_POS1:     hall_pos_reg[0] <= pwdata[POS_W-1:0];
                REG_POS2:     hall_pos_reg[1] <= pwdata[POS_W-1:0];
                REG_POS3:     hall_pos_reg[2] <= pwdata[POS_W-1:0];
                REG_POS4:     hall_pos_reg[3] <= pwdata[POS_W-1:0];
                REG_POS5:     hall_pos_reg[4] <= pwdata[POS_W-1:0];
                REG_POS6:     hall_pos_reg[5] <= pwdata[POS_W-1:0];
                REG_INTERVAL: interval_reg    <= pwdata[INTERVAL_W-1:0];
                REG_SCALE:    scale_reg       <= pwdata[SCALE_W-1:0];
                default:      scale_reg       <= scale_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_POS1:     prdata = DATA_W'(hall_pos_reg[0]);
            REG_POS2:     prdata = DATA_W'(hall_pos_reg[1]);
            REG_POS3:     prdata = DATA_W'(hall_pos_reg[2]);
            REG_POS4:     prdata = DATA_W'(hall_pos_reg[3]);
            REG_POS5:     prdata = DATA_W'(hall_pos_reg[4]);
            REG_POS6:     prdata = DATA_W'(hall_pos_reg[5]);
            REG_INTERVAL: prdata = DATA_W'(interval_reg);
            REG_SCALE:    prdata = DATA_W'(scale_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.hall_pos = hall_pos_reg;
    assign cfg.interval = interval_reg;
    assign cfg.scale    = scale_reg;

    // two-stage pipeline handshake
    assign b_block   = out_valid_reg && out_stall;
    assign in_stall  = a_valid_reg && b_block;
    assign in_accept = in_valid && !in_stall;
    assign a_move    = a_valid_reg && !b_block;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                a_valid_reg <= in_valid;
            if (!b_block)
                out_valid_reg <= a_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    hspv_decode #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .op     (op),
        .hall_a (hall_a),
        .hall_b (hall_b),
        .hall_z (hall_z),
        .now_us (now_us),
        .cfg    (cfg),
        .stage  (stage)
    );

    hspv_velocity u_velocity (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (a_move),
        .stage       (stage),
        .scale       (cfg.scale),
        .position    (position),
        .sector      (sector),
        .hall_state  (hall_state),
        .velocity_q8 (velocity_q8),
        .status      (status)
    );

endmodule

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hspv_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_ITEMS = 120;

    typedef struct packed {
        logic [COUNT_W-1:0]  position;
        logic [SECTOR_W-1:0] sector;
        logic [STATE_W-1:0]  hall_state;
        logic [VEL_W-1:0]    velocity;
        status_t             status;
    } hall_result_t;

    typedef struct {
        bit                  is_cfg;
        reg_idx_t            reg_sel;
        logic [DATA_W-1:0]   value;
        op_t                 opcode;
        logic [STATE_W-1:0]  hs;
        logic [TIME_W-1:0]   stamp;
        bit                  known;
        hall_result_t        result;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       op = OP_SAMPLE;
    logic                       hall_a = 1'b0;
    logic                       hall_b = 1'b0;
    logic                       hall_z = 1'b0;
    logic [TIME_W-1:0]          now_us = '0;

    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [COUNT_W-1:0]  position;
    logic signed [SECTOR_W-1:0] sector;
    logic [STATE_W-1:0]         hall_state;
    logic signed [VEL_W-1:0]    velocity_q8;
    logic [1:0]                 status;

    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_W-1:0]          paddr = '0;
    logic [DATA_W-1:0]          pwdata = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    // shadow of the block's calibration and tracking state
    logic [POS_W-1:0]      cal_tab [NUM_HALL_POS] = '{default: '0};
    logic [INTERVAL_W-1:0] interval_cfg = INTERVAL_RESET;
    logic [SCALE_W-1:0]    scale_cfg = SCALE_RESET;
    logic [COUNT_W-1:0]    run_count = '0;
    logic [STATE_W-1:0]    last_state = STATE_NONE;
    logic [COUNT_W-1:0]    window_hist [DEFAULT_WINDOW_DEPTH] = '{default: '0};
    int                    win_ptr = 0;
    logic [TIME_W-1:0]     last_sample = '0;
    logic [VEL_W-1:0]      vel_held = '0;

    hall_result_t expected_readings [$];
    stim_row_t    stim_rows [$];
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           stall_left = 0;
    bit           idling = 1'b1;

    hall_sensor_position_velocity dut (.*);

    always #2 clk = ~clk;

    function automatic hall_result_t predict_reading(op_t o, logic [STATE_W-1:0] hs,
                                                     logic [TIME_W-1:0] t);
        hall_result_t r;
        logic [STATE_W-1:0] s;
        int oldp;
        int newp;
        logic [TIME_W-1:0] elapsed;
        logic [COUNT_W-1:0] oldest;
        logic signed [COUNT_W-1:0] diff;
        longint prod;
        r.status = STATUS_OK;
        if (o == OP_ZERO) begin
            run_count = '0;
            vel_held = '0;
            foreach (window_hist[i]) window_hist[i] = '0;
        end else begin
            s = (hs == STATE_ALL) ? STATE_NONE : hs;
            if (s == STATE_NONE)
                r.status = STATUS_INVALID;
            else if (last_state != STATE_NONE) begin
                oldp = cal_tab[last_state - 1];
                newp = cal_tab[s - 1];
                if (newp == (oldp + 1) % 6)
                    run_count = run_count + 1;
                else if ((oldp >= 1 && newp == (oldp - 1) % 6) || (oldp == 0 && newp == 5))
                    run_count = run_count - 1;
                else if (newp != oldp)
                    r.status = STATUS_SKIP;
            end
            last_state = s;

            elapsed = t - last_sample;
            if (elapsed >= TIME_W'(interval_cfg)) begin
                oldest = window_hist[win_ptr];
                last_sample = last_sample + TIME_W'(interval_cfg);
                window_hist[win_ptr] = run_count;
                win_ptr = (win_ptr + 1) % DEFAULT_WINDOW_DEPTH;
                diff = run_count - oldest;
                prod = longint'(diff) * longint'(scale_cfg);
                if (prod > 64'sd2147483647)
                    vel_held = 32'h7FFF_FFFF;
                else if (prod < -64'sd2147483648)
                    vel_held = 32'h8000_0000;
                else
                    vel_held = prod[31:0];
            end
        end
        r.position = run_count;
        r.sector = (last_state != STATE_NONE) ? {1'b0, cal_tab[last_state - 1]} : SECTOR_NONE;
        r.hall_state = last_state;
        r.velocity = vel_held;
        return r;
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        hall_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_readings.size() == 0) begin
                $display("%0t ns: result with no item pending, position %0h", $time, position);
                mismatches++;
            end else begin
                want = expected_readings.pop_front();
                check_field("position", want.position, position);
                check_field("sector", {28'd0, want.sector}, {28'd0, sector});
                check_field("hall_state", {29'd0, want.hall_state}, {29'd0, hall_state});
                check_field("velocity_q8", want.velocity, velocity_q8);
                check_field("status", {30'd0, want.status}, {30'd0, status});
            end
        end
    end

    // output side back-pressure in bursts
    always @(posedge clk) begin
        if (stall_left == 0 && idling && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 16);
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else
            out_stall <= 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic add_sample(op_t o, logic [STATE_W-1:0] hs, logic [TIME_W-1:0] t,
                              bit known = 1'b0, logic [COUNT_W-1:0] pos = '0,
                              logic [SECTOR_W-1:0] sec = '0, logic [STATE_W-1:0] st = '0,
                              status_t stat = STATUS_OK);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.reg_sel = REG_POS1;
        row.value = '0;
        row.opcode = o;
        row.hs = hs;
        row.stamp = t;
        row.known = known;
        row.result = '{pos, sec, st, '0, stat};
        stim_rows.push_back(row);
    endtask

    task automatic add_cfg(reg_idx_t r, logic [DATA_W-1:0] v);
        stim_row_t row;
        row.is_cfg = 1'b1;
        row.reg_sel = r;
        row.value = v;
        row.opcode = OP_SAMPLE;
        row.hs = '0;
        row.stamp = '0;
        row.known = 1'b0;
        row.result = '0;
        stim_rows.push_back(row);
    endtask

    // called at a clock edge; returns at the edge the item is taken
    task automatic send_reading(op_t o, logic [STATE_W-1:0] hs, logic [TIME_W-1:0] t,
                                bit known, hall_result_t fixed);
        hall_result_t r;
        if (idling && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        hall_a <= hs[2];
        hall_b <= hs[1];
        hall_z <= hs[0];
        now_us <= t;
        do @(posedge clk); while (in_stall);
        r = predict_reading(o, hs, t);
        expected_readings.push_back(known ? fixed : r);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t r, logic [DATA_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * r);
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_INTERVAL: interval_cfg = v[INTERVAL_W-1:0];
            REG_SCALE:    scale_cfg = v[SCALE_W-1:0];
            default:      cal_tab[r - REG_POS1] = v[POS_W-1:0];
        endcase
        @(posedge clk);
    endtask

    initial begin
        logic [STATE_W-1:0]    ring [NUM_HALL_POS];
        logic [POS_W-1:0]      new_cal [NUM_HALL_POS];
        logic [STATE_W-1:0]    swap;
        logic [STATE_W-1:0]    hs;
        logic [INTERVAL_W-1:0] new_interval;
        logic [SCALE_W-1:0]    new_scale;
        logic [TIME_W-1:0]     clock_us;
        op_t                   o;
        int                    sec_pos;
        int                    dir;
        int                    tstep;
        int                    pick;
        int                    j;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration: everything maps to sector 0
        add_sample(OP_SAMPLE, 3'b000, 32'd0, 1'b1, '0, SECTOR_NONE, STATE_NONE, STATUS_INVALID);
        add_sample(OP_SAMPLE, 3'b111, 32'd1, 1'b1, '0, SECTOR_NONE, STATE_NONE, STATUS_INVALID);
        add_sample(OP_SAMPLE, 3'b001, 32'd2, 1'b1, '0, 4'd0, 3'd1, STATUS_OK);
        add_sample(OP_SAMPLE, 3'b010, 32'd3);
        add_sample(OP_ZERO, 3'b111, 32'hFFFF_FFFF, 1'b1, '0, 4'd0, 3'd2, STATUS_OK);
        // commutation order 1,3,2,6,4,5
        add_cfg(REG_POS1, 32'd0);
        add_cfg(REG_POS2, 32'd2);
        add_cfg(REG_POS3, 32'd1);
        add_cfg(REG_POS4, 32'd4);
        add_cfg(REG_POS5, 32'd5);
        add_cfg(REG_POS6, 32'd3);
        add_sample(OP_SAMPLE, 3'b011, 32'd10);
        add_sample(OP_SAMPLE, 3'b001, 32'd20);
        add_sample(OP_SAMPLE, 3'b101, 32'd30);
        add_sample(OP_SAMPLE, 3'b001, 32'd40);
        add_sample(OP_SAMPLE, 3'b010, 32'd50, 1'b1, 32'hFFFF_FFFE, 4'd2, 3'd2, STATUS_SKIP);
        add_sample(OP_SAMPLE, 3'b111, 32'd60, 1'b1, 32'hFFFF_FFFE, SECTOR_NONE, STATE_NONE,
                   STATUS_INVALID);
        add_sample(OP_SAMPLE, 3'b100, 32'd110);
        add_sample(OP_SAMPLE, 3'b100, 32'd1000);
        add_sample(OP_SAMPLE, 3'b101, 32'hFFFF_FFFF);
        add_sample(OP_ZERO, 3'b000, 32'd0, 1'b1, '0, 4'd5, 3'd5, STATUS_OK);
        // sample every step at full scale; calibration values past the sector range
        add_cfg(REG_INTERVAL, 32'd0);
        add_cfg(REG_SCALE, 32'h00FF_FFFF);
        add_cfg(REG_POS1, 32'd7);
        add_cfg(REG_POS3, 32'd6);
        add_sample(OP_SAMPLE, 3'b001, 32'd0);
        add_sample(OP_SAMPLE, 3'b011, 32'd0);
        add_sample(OP_SAMPLE, 3'b101, 32'd0);
        add_sample(OP_SAMPLE, 3'b001, 32'd0);
        add_sample(OP_SAMPLE, 3'b010, 32'd0);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg) begin
                drain_results();
                apb_write(stim_rows[i].reg_sel, stim_rows[i].value);
            end else
                send_reading(stim_rows[i].opcode, stim_rows[i].hs, stim_rows[i].stamp,
                             stim_rows[i].known, stim_rows[i].result);
        end

        clock_us = 32'hFFFF_FF00;
        sec_pos = 0;
        dir = 1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            idling = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);

            for (int k = 0; k < NUM_HALL_POS; k++) ring[k] = STATE_W'(k + 1);
            for (int k = NUM_HALL_POS - 1; k > 0; k--) begin
                j = $urandom_range(0, k);
                swap = ring[k];
                ring[k] = ring[j];
                ring[j] = swap;
            end
            for (int k = 0; k < NUM_HALL_POS; k++) new_cal[ring[k] - 1] = POS_W'(k);
            if (phase % 3 == 0) begin
                for (int k = 0; k < NUM_HALL_POS; k++) new_cal[k] = POS_W'($urandom_range(0, 7));
                if (phase == 0) begin
                    new_cal[0] = 3'd7;
                    new_cal[1] = 3'd6;
                end
            end

            case ($urandom_range(0, 4))
                0:       new_interval = 20'd1;
                1:       new_interval = 20'($urandom_range(2, 200));
                2:       new_interval = 20'd1000;
                3:       new_interval = 20'($urandom);
                default: new_interval = 20'($urandom_range(20, 2000));
            endcase
            case ($urandom_range(0, 3))
                0:       new_scale = 24'($urandom);
                1:       new_scale = SCALE_RESET;
                2:       new_scale = 24'($urandom_range(0, 255));
                default: new_scale = 24'hFF_FFFF;
            endcase
            tstep = $urandom_range(1, 64);
            if (phase == 0) begin
                new_interval = 20'hF_FFFF;
                new_scale = 24'hFF_FFFF;
            end else if (phase == 1) begin
                new_interval = '0;
                new_scale = '0;
            end else if (phase == NUM_PHASES - 1) begin
                // long runs per window sample, so the velocity clips
                new_interval = 20'd1000;
                new_scale = 24'hFF_FFFF;
                tstep = 64;
            end

            for (int k = 0; k < NUM_HALL_POS; k++)
                apb_write(reg_idx_t'(REG_POS1 + k), DATA_W'(new_cal[k]));
            apb_write(REG_INTERVAL, DATA_W'(new_interval));
            apb_write(REG_SCALE, DATA_W'(new_scale));

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                o = OP_SAMPLE;
                if (pick < 2)
                    clock_us = $urandom;
                else
                    clock_us = clock_us + TIME_W'($urandom_range(0, tstep));
                if (pick < 70) begin
                    if ($urandom_range(0, 63) == 0) dir = -dir;
                    sec_pos = (sec_pos + dir + 6) % 6;
                    hs = ring[sec_pos];
                end else if (pick < 80)
                    hs = 3'($urandom);
                else if (pick < 86)
                    hs = $urandom_range(0, 1) ? STATE_ALL : STATE_NONE;
                else if (pick < 90) begin
                    o = OP_ZERO;
                    hs = 3'($urandom);
                end else if (pick < 95)
                    hs = ring[(sec_pos + 2 + $urandom_range(0, 2)) % 6];
                else
                    hs = ring[sec_pos];
                send_reading(o, hs, clock_us, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
